@@ hw/rtl/closest_point_on_segment_assert.svh @@
// assertion macros for the closest point on segment block
// used by the port checker, no other dependencies
`ifndef CLOSEST_POINT_ON_SEGMENT_ASSERT_SVH
`define CLOSEST_POINT_ON_SEGMENT_ASSERT_SVH

// same-cycle implication
`define CPS_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("cps assertion failed");

// next-cycle implication
`define CPS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("cps assertion failed");

`endif

@@ hw/rtl/cps_pkg.sv @@
// shared widths, register indexes and stage payload types
// for the closest point on segment pipeline, no dependencies
`default_nettype none
package cps_pkg;

   localparam int COORD_W = 24;
   localparam int DELTA_W = COORD_W + 1;
   localparam int HALF_W  = DELTA_W;
   localparam int PROD_W  = 2 * DELTA_W;
   localparam int NUM_W   = PROD_W + 1;
   localparam int DEN_W   = PROD_W;
   localparam int N_W     = 3 * HALF_W;
   localparam int Q_W     = N_W - DEN_W;
   localparam int M_W     = Q_W + 1;
   localparam int SUM_W   = M_W + 2;
   localparam int SQ_W    = PROD_W;
   localparam int ROOT_W  = SQ_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int IDX_W   = 2;

   localparam logic [IDX_W-1:0] REG_START_X = 2'd0;
   localparam logic [IDX_W-1:0] REG_START_Y = 2'd1;
   localparam logic [IDX_W-1:0] REG_END_X   = 2'd2;
   localparam logic [IDX_W-1:0] REG_END_Y   = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } line_type;

   typedef struct packed {
      coord_type qx;
      coord_type qy;
      logic      degen;
   } point_type;

   typedef struct packed {
      logic [N_W-1:0]   nx;
      logic [N_W-1:0]   ny;
      logic [DEN_W-1:0] den;
      logic             negx;
      logic             negy;
      point_type        pt;
   } quot_req_type;

   typedef struct packed {
      logic [M_W-1:0] mx;
      logic [M_W-1:0] my;
      logic           negx;
      logic           negy;
      point_type      pt;
   } quot_rsp_type;

   typedef struct packed {
      logic [SQ_W-1:0] sq;
      coord_type       cx;
      coord_type       cy;
      logic            degen;
   } root_req_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      coord_type         cx;
      coord_type         cy;
      logic              degen;
   } root_rsp_type;

endpackage
`default_nettype wire

@@ hw/rtl/cps_proj.sv @@
// projection front end: offsets, dot products, clamp and scaled numerators
// depends on cps_pkg
`default_nettype none
module cps_proj
   import cps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  coord_type    query_x,
   input  coord_type    query_y,
   input  logic         seg,
   input  line_type     line,
   output logic         out_valid,
   output quot_req_type out_req
);

   logic [5:0] v_ff;

   logic signed [DELTA_W-1:0] ax1_ff, ay1_ff, dx1_ff, dy1_ff;
   coord_type                 px1_ff, py1_ff;
   logic                      seg1_ff;

   logic signed [PROD_W-1:0]  pad2_ff, pbd2_ff, pdd2_ff, pee2_ff;
   logic signed [DELTA_W-1:0] dx2_ff, dy2_ff;
   coord_type                 px2_ff, py2_ff;
   logic                      seg2_ff;

   logic signed [NUM_W-1:0]   num3_ff;
   logic [DEN_W-1:0]          den3_ff;
   logic signed [DELTA_W-1:0] dx3_ff, dy3_ff;
   coord_type                 px3_ff, py3_ff;
   logic                      seg3_ff;

   logic signed [NUM_W-1:0]   den3_s;
   logic signed [NUM_W-1:0]   numc;
   logic                      neg4_in;
   logic [DEN_W-1:0]          mag4_in, mag4_ff, den4_ff;
   logic [HALF_W-1:0]         adx4_in, ady4_in, adx4_ff, ady4_ff;
   logic                      negx4_ff, negy4_ff;
   point_type                 pt4_ff;

   logic [PROD_W-1:0]         plx5_ff, phx5_ff, ply5_ff, phy5_ff;
   logic [DEN_W-1:0]          den5_ff;
   logic                      negx5_ff, negy5_ff;
   point_type                 pt5_ff;

   quot_req_type              req6_ff;

   always_comb begin
      den3_s = $signed({1'b0, den3_ff});
      numc   = num3_ff;
      if (seg3_ff) begin
         if (num3_ff < 0) begin
            numc = '0;
         end else if (num3_ff > den3_s) begin
            numc = den3_s;
         end
      end
      neg4_in = numc[NUM_W-1];
      mag4_in = neg4_in ? DEN_W'(-numc) : DEN_W'(numc);
      adx4_in = dx3_ff[DELTA_W-1] ? HALF_W'(-dx3_ff) : HALF_W'(dx3_ff);
      ady4_in = dy3_ff[DELTA_W-1] ? HALF_W'(-dy3_ff) : HALF_W'(dy3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // offsets from the start point
         ax1_ff  <= DELTA_W'(query_x) - DELTA_W'(line.start_x);
         ay1_ff  <= DELTA_W'(query_y) - DELTA_W'(line.start_y);
         dx1_ff  <= DELTA_W'(line.end_x) - DELTA_W'(line.start_x);
         dy1_ff  <= DELTA_W'(line.end_y) - DELTA_W'(line.start_y);
         px1_ff  <= query_x;
         py1_ff  <= query_y;
         seg1_ff <= seg;

         pad2_ff <= ax1_ff * dx1_ff;
         pbd2_ff <= ay1_ff * dy1_ff;
         pdd2_ff <= dx1_ff * dx1_ff;
         pee2_ff <= dy1_ff * dy1_ff;
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         px2_ff  <= px1_ff;
         py2_ff  <= py1_ff;
         seg2_ff <= seg1_ff;

         num3_ff <= NUM_W'(pad2_ff) + NUM_W'(pbd2_ff);
         den3_ff <= DEN_W'($unsigned(pdd2_ff)) + DEN_W'($unsigned(pee2_ff));
         dx3_ff  <= dx2_ff;
         dy3_ff  <= dy2_ff;
         px3_ff  <= px2_ff;
         py3_ff  <= py2_ff;
         seg3_ff <= seg2_ff;

         // clamp and sign split
         mag4_ff      <= mag4_in;
         den4_ff      <= den3_ff;
         adx4_ff      <= adx4_in;
         ady4_ff      <= ady4_in;
         negx4_ff     <= neg4_in ^ dx3_ff[DELTA_W-1];
         negy4_ff     <= neg4_in ^ dy3_ff[DELTA_W-1];
         pt4_ff.qx    <= px3_ff;
         pt4_ff.qy    <= py3_ff;
         pt4_ff.degen <= (den3_ff == '0);

         // partial products of the numerator times the direction
         plx5_ff  <= mag4_ff[HALF_W-1:0] * adx4_ff;
         phx5_ff  <= mag4_ff[DEN_W-1:HALF_W] * adx4_ff;
         ply5_ff  <= mag4_ff[HALF_W-1:0] * ady4_ff;
         phy5_ff  <= mag4_ff[DEN_W-1:HALF_W] * ady4_ff;
         den5_ff  <= den4_ff;
         negx5_ff <= negx4_ff;
         negy5_ff <= negy4_ff;
         pt5_ff   <= pt4_ff;

         req6_ff.nx   <= (N_W'(phx5_ff) << HALF_W) + N_W'(plx5_ff);
         req6_ff.ny   <= (N_W'(phy5_ff) << HALF_W) + N_W'(ply5_ff);
         req6_ff.den  <= den5_ff;
         req6_ff.negx <= negx5_ff;
         req6_ff.negy <= negy5_ff;
         req6_ff.pt   <= pt5_ff;
      end
   end

   assign out_valid = v_ff[5];
   assign out_req   = req6_ff;

endmodule
`default_nettype wire

@@ hw/rtl/cps_div.sv @@
// pipelined restoring divider, one quotient bit per stage, both axes
// with overflow detect and round half away from zero, depends on cps_pkg
`default_nettype none
module cps_div
   import cps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  quot_req_type in_req,
   output logic         out_valid,
   output quot_rsp_type out_rsp
);

   logic [Q_W+1:0]   v_ff;
   logic [DEN_W-1:0] remx_ff [0:Q_W];
   logic [DEN_W-1:0] remy_ff [0:Q_W];
   logic [Q_W-1:0]   lowx_ff [0:Q_W];
   logic [Q_W-1:0]   lowy_ff [0:Q_W];
   logic [Q_W-1:0]   qx_ff   [0:Q_W];
   logic [Q_W-1:0]   qy_ff   [0:Q_W];
   logic [DEN_W-1:0] den_ff  [0:Q_W];
   logic             ovfx_ff [0:Q_W];
   logic             ovfy_ff [0:Q_W];
   logic             negx_ff [0:Q_W];
   logic             negy_ff [0:Q_W];
   point_type        pt_ff   [0:Q_W];

   logic [DEN_W:0]   stepx_in [1:Q_W];
   logic [DEN_W:0]   stepy_in [1:Q_W];
   logic             rndx, rndy;
   logic [M_W-1:0]   mx_in, my_in;
   quot_rsp_type     rsp_ff;

   function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                               input logic             bit_in,
                                               input logic [DEN_W-1:0] den);
      logic [DEN_W:0] trial;
      logic           ge;
      trial = {rem, bit_in};
      ge    = (trial >= {1'b0, den});
      if (ge) begin
         trial = trial - {1'b0, den};
      end
      return {trial[DEN_W-1:0], ge};
   endfunction

   always_comb begin
      for (int k = 1; k <= Q_W; k++) begin
         stepx_in[k] = div_step(remx_ff[k-1], lowx_ff[k-1][Q_W-1], den_ff[k-1]);
         stepy_in[k] = div_step(remy_ff[k-1], lowy_ff[k-1][Q_W-1], den_ff[k-1]);
      end
      rndx  = ({remx_ff[Q_W], 1'b0} >= {1'b0, den_ff[Q_W]});
      rndy  = ({remy_ff[Q_W], 1'b0} >= {1'b0, den_ff[Q_W]});
      mx_in = ovfx_ff[Q_W] ? {1'b1, {Q_W{1'b0}}} : {1'b0, qx_ff[Q_W]} + M_W'(rndx);
      my_in = ovfy_ff[Q_W] ? {1'b1, {Q_W{1'b0}}} : {1'b0, qy_ff[Q_W]} + M_W'(rndy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[Q_W:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // load the first stage and flag a quotient too large for the Q_W-bit quotient field
         remx_ff[0] <= in_req.nx[N_W-1 -: DEN_W];
         remy_ff[0] <= in_req.ny[N_W-1 -: DEN_W];
         lowx_ff[0] <= in_req.nx[Q_W-1:0];
         lowy_ff[0] <= in_req.ny[Q_W-1:0];
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         ovfx_ff[0] <= (in_req.nx[N_W-1 -: DEN_W] >= in_req.den);
         ovfy_ff[0] <= (in_req.ny[N_W-1 -: DEN_W] >= in_req.den);
         den_ff[0]  <= in_req.den;
         negx_ff[0] <= in_req.negx;
         negy_ff[0] <= in_req.negy;
         pt_ff[0]   <= in_req.pt;
         for (int k = 1; k <= Q_W; k++) begin
            remx_ff[k] <= stepx_in[k][DEN_W:1];
            remy_ff[k] <= stepy_in[k][DEN_W:1];
            lowx_ff[k] <= lowx_ff[k-1] << 1;
            lowy_ff[k] <= lowy_ff[k-1] << 1;
            qx_ff[k]   <= {qx_ff[k-1][Q_W-2:0], stepx_in[k][0]};
            qy_ff[k]   <= {qy_ff[k-1][Q_W-2:0], stepy_in[k][0]};
            ovfx_ff[k] <= ovfx_ff[k-1];
            ovfy_ff[k] <= ovfy_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            negx_ff[k] <= negx_ff[k-1];
            negy_ff[k] <= negy_ff[k-1];
            pt_ff[k]   <= pt_ff[k-1];
         end
         rsp_ff.mx   <= mx_in;
         rsp_ff.my   <= my_in;
         rsp_ff.negx <= negx_ff[Q_W];
         rsp_ff.negy <= negy_ff[Q_W];
         rsp_ff.pt   <= pt_ff[Q_W];
      end
   end

   assign out_valid = v_ff[Q_W+1];
   assign out_rsp   = rsp_ff;

endmodule
`default_nettype wire

@@ hw/rtl/cps_isqrt.sv @@
// pipelined integer square root, one result bit per stage
// depends on cps_pkg
`default_nettype none
module cps_isqrt
   import cps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  root_req_type in_req,
   output logic         out_valid,
   output root_rsp_type out_rsp
);

   logic [ROOT_W:0]   v_ff;
   logic [SQ_W-1:0]   sq_ff   [0:ROOT_W];
   logic [REM_W-1:0]  rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W];
   coord_type         cx_ff   [0:ROOT_W];
   coord_type         cy_ff   [0:ROOT_W];
   logic              dg_ff   [0:ROOT_W];

   logic [REM_W+1:0]  shl_in   [1:ROOT_W];
   logic [REM_W+1:0]  trial_in [1:ROOT_W];
   logic              ge_in    [1:ROOT_W];
   logic [REM_W+1:0]  diff_in  [1:ROOT_W];

   always_comb begin
      for (int k = 1; k <= ROOT_W; k++) begin
         shl_in[k]   = {rem_ff[k-1], sq_ff[k-1][SQ_W-1 -: 2]};
         trial_in[k] = (REM_W + 2)'({root_ff[k-1], 2'b01});
         ge_in[k]    = (shl_in[k] >= trial_in[k]);
         diff_in[k]  = ge_in[k] ? shl_in[k] - trial_in[k] : shl_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[ROOT_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff[0]   <= in_req.sq;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         cx_ff[0]   <= in_req.cx;
         cy_ff[0]   <= in_req.cy;
         dg_ff[0]   <= in_req.degen;
         for (int k = 1; k <= ROOT_W; k++) begin
            sq_ff[k]   <= sq_ff[k-1] << 2;
            rem_ff[k]  <= diff_in[k][REM_W-1:0];
            root_ff[k] <= {root_ff[k-1][ROOT_W-2:0], ge_in[k]};
            cx_ff[k]   <= cx_ff[k-1];
            cy_ff[k]   <= cy_ff[k-1];
            dg_ff[k]   <= dg_ff[k-1];
         end
      end
   end

   assign out_valid     = v_ff[ROOT_W];
   assign out_rsp.root  = root_ff[ROOT_W];
   assign out_rsp.cx    = cx_ff[ROOT_W];
   assign out_rsp.cy    = cy_ff[ROOT_W];
   assign out_rsp.degen = dg_ff[ROOT_W];

endmodule
`default_nettype wire

@@ hw/rtl/closest_point_on_segment.sv @@
// Closest point on a configured line or segment, Q15.8 coordinates. One request
// is taken every clock cycle unless req_stall is high and goes through 6 stages
// of projection arithmetic, 27 of the quotient divider (one bit per stage plus
// overflow check and rounding), 3 for saturation, offset and squaring, and 26 of
// the square root (one bit per stage). The whole pipeline holds while a response
// waits under stall, so requests are stalled exactly then. Line registers are to
// be written through the csr port only while no request is in flight; the block
// does not enforce this; depends on cps_pkg, cps_proj, cps_div and cps_isqrt
`default_nettype none
module closest_point_on_segment
   import cps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  coord_type         req_query_x,
   input  coord_type         req_query_y,
   input  logic              req_segment_mode,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output coord_type         rsp_closest_x,
   output coord_type         rsp_closest_y,
   output logic [ROOT_W-1:0] rsp_distance,
   output logic              rsp_degenerate,
   input  logic              csr_write_en,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [COORD_W-1:0] csr_wdata
);

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (COORD_W - 1) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(2 ** (COORD_W - 1));

   line_type     line_ff;
   logic         adv;
   logic         proj_valid, div_valid, root_valid;
   quot_req_type proj_req;
   quot_rsp_type div_rsp;
   root_req_type root_req;
   root_rsp_type root_rsp;

   logic [2:0]                tv_ff;
   logic signed [SUM_W-1:0]   sumx_in, sumy_in;
   coord_type                 cx_in, cy_in;
   coord_type                 cx1_ff, cy1_ff, qx1_ff, qy1_ff;
   logic                      dg1_ff;
   logic signed [DELTA_W-1:0] ox_in, oy_in;
   logic [DELTA_W-1:0]        aox2_ff, aoy2_ff;
   coord_type                 cx2_ff, cy2_ff;
   logic                      dg2_ff;
   logic [SQ_W-1:0]           sqx3_ff, sqy3_ff;
   coord_type                 cx3_ff, cy3_ff;
   logic                      dg3_ff;

   function automatic coord_type sat_coord(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] s;
      s = v;
      if (v > SAT_HI) begin
         s = SAT_HI;
      end else if (v < SAT_LO) begin
         s = SAT_LO;
      end
      return s[COORD_W-1:0];
   endfunction

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_START_X: line_ff.start_x <= csr_wdata;
            REG_START_Y: line_ff.start_y <= csr_wdata;
            REG_END_X:   line_ff.end_x   <= csr_wdata;
            REG_END_Y:   line_ff.end_y   <= csr_wdata;
            default: ;
         endcase
      end
   end

   cps_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .query_x   (req_query_x),
      .query_y   (req_query_y),
      .seg       (req_segment_mode),
      .line      (line_ff),
      .out_valid (proj_valid),
      .out_req   (proj_req)
   );

   cps_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (proj_valid),
      .in_req    (proj_req),
      .out_valid (div_valid),
      .out_rsp   (div_rsp)
   );

   always_comb begin
      sumx_in = SUM_W'(line_ff.start_x)
              + (div_rsp.negx ? -SUM_W'(div_rsp.mx) : SUM_W'(div_rsp.mx));
      sumy_in = SUM_W'(line_ff.start_y)
              + (div_rsp.negy ? -SUM_W'(div_rsp.my) : SUM_W'(div_rsp.my));
      // zero-length line returns the start point
      cx_in   = div_rsp.pt.degen ? line_ff.start_x : sat_coord(sumx_in);
      cy_in   = div_rsp.pt.degen ? line_ff.start_y : sat_coord(sumy_in);
      ox_in   = DELTA_W'(qx1_ff) - DELTA_W'(cx1_ff);
      oy_in   = DELTA_W'(qy1_ff) - DELTA_W'(cy1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= '0;
      end else if (adv) begin
         tv_ff <= {tv_ff[1:0], div_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx1_ff  <= cx_in;
         cy1_ff  <= cy_in;
         qx1_ff  <= div_rsp.pt.qx;
         qy1_ff  <= div_rsp.pt.qy;
         dg1_ff  <= div_rsp.pt.degen;

         aox2_ff <= ox_in[DELTA_W-1] ? DELTA_W'(-ox_in) : DELTA_W'(ox_in);
         aoy2_ff <= oy_in[DELTA_W-1] ? DELTA_W'(-oy_in) : DELTA_W'(oy_in);
         cx2_ff  <= cx1_ff;
         cy2_ff  <= cy1_ff;
         dg2_ff  <= dg1_ff;

         sqx3_ff <= aox2_ff * aox2_ff;
         sqy3_ff <= aoy2_ff * aoy2_ff;
         cx3_ff  <= cx2_ff;
         cy3_ff  <= cy2_ff;
         dg3_ff  <= dg2_ff;
      end
   end

   assign root_req.sq    = sqx3_ff + sqy3_ff;
   assign root_req.cx    = cx3_ff;
   assign root_req.cy    = cy3_ff;
   assign root_req.degen = dg3_ff;

   cps_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (tv_ff[2]),
      .in_req    (root_req),
      .out_valid (root_valid),
      .out_rsp   (root_rsp)
   );

   assign rsp_valid      = root_valid;
   assign rsp_closest_x  = root_rsp.cx;
   assign rsp_closest_y  = root_rsp.cy;
   assign rsp_distance   = root_rsp.root;
   assign rsp_degenerate = root_rsp.degen;

endmodule
`default_nettype wire

@@ hw/rtl/cps_checker.sv @@
// port checker for closest_point_on_segment, bound to the top level
// depends on cps_pkg and closest_point_on_segment_assert.svh
`default_nettype none
`include "closest_point_on_segment_assert.svh"
module cps_checker
   import cps_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input coord_type         rsp_closest_x,
   input coord_type         rsp_closest_y,
   input logic [ROOT_W-1:0] rsp_distance,
   input logic              rsp_degenerate
);

   // requests are held back only by a stalled response
   `CPS_ASSERT_NOW(a_stall_source, clock, reset, req_stall, rsp_valid && rsp_stall)

   `CPS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   `CPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   `CPS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_closest_x) && $stable(rsp_closest_y) && $stable(rsp_distance) && $stable(rsp_degenerate))

endmodule

bind closest_point_on_segment cps_checker u_checker (.*);
`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench for closest_point_on_segment: directed and random queries
// against an internal projection predictor, with random idling and stall pressure
// depends on cps_pkg and the closest_point_on_segment rtl
`default_nettype none
module testbench;
   import cps_pkg::*;

   typedef struct {
      coord_type         cx;
      coord_type         cy;
      logic [ROOT_W-1:0] distance_val;
      logic              degen;
   } closest_result_type;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   coord_type         req_query_x = '0;
   coord_type         req_query_y = '0;
   logic              req_segment_mode = 0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   coord_type         rsp_closest_x;
   coord_type         rsp_closest_y;
   logic [ROOT_W-1:0] rsp_distance;
   logic              rsp_degenerate;
   logic              csr_write_en = 0;
   logic [IDX_W-1:0]  csr_index = '0;
   logic [COORD_W-1:0] csr_wdata = '0;

   closest_result_type expected_points[$];
   line_type          line_regs;
   int                failures = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   int                hold_cycles = 0;

   closest_point_on_segment dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic longint round_offset(longint num, longint d, longint den);
      logic [127:0] mag, q, r, den_w;
      longint       m;
      den_w = 128'(den);
      mag = 128'(num < 0 ? -num : num) * 128'(d < 0 ? -d : d);
      q = mag / den_w;
      r = mag % den_w;
      if ((r << 1) >= den_w)
         q = q + 1;
      if (q > (128'd1 << 40))
         q = 128'd1 << 40;
      m = longint'(q[63:0]);
      return ((num < 0) != (d < 0)) ? -m : m;
   endfunction

   function automatic longint saturate_coord(longint v);
      if (v > 64'sd8388607)
         return 64'sd8388607;
      if (v < -64'sd8388608)
         return -64'sd8388608;
      return v;
   endfunction

   function automatic closest_result_type project_point(coord_type qx, coord_type qy,
                                                        logic seg);
      closest_result_type res;
      longint sx, sy, dx, dy, ax, ay, num, den, cx, cy, ox, oy, sq, root, t;
      sx = line_regs.start_x;
      sy = line_regs.start_y;
      dx = longint'(line_regs.end_x) - sx;
      dy = longint'(line_regs.end_y) - sy;
      ax = longint'(qx) - sx;
      ay = longint'(qy) - sy;
      den = dx * dx + dy * dy;
      cx = sx;
      cy = sy;
      res.degen = (den == 0);
      if (den != 0) begin
         num = ax * dx + ay * dy;
         if (seg) begin
            if (num < 0)
               num = 0;
            else if (num > den)
               num = den;
         end
         cx = saturate_coord(sx + round_offset(num, dx, den));
         cy = saturate_coord(sy + round_offset(num, dy, den));
      end
      ox = longint'(qx) - cx;
      oy = longint'(qy) - cy;
      sq = ox * ox + oy * oy;
      root = 0;
      for (int i = 26; i >= 0; i--) begin
         t = root | (64'sd1 << i);
         if (t * t <= sq)
            root = t;
      end
      res.cx = coord_type'(cx);
      res.cy = coord_type'(cy);
      res.distance_val = root[ROOT_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      closest_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected response x=%0d y=%0d", $time, rsp_closest_x,
                     rsp_closest_y);
            failures++;
         end else begin
            exp_res = expected_points.pop_front();
            if (rsp_closest_x !== exp_res.cx) begin
               $display("%0t: closest_x expected %0d actual %0d", $time, exp_res.cx,
                        rsp_closest_x);
               failures++;
            end
            if (rsp_closest_y !== exp_res.cy) begin
               $display("%0t: closest_y expected %0d actual %0d", $time, exp_res.cy,
                        rsp_closest_y);
               failures++;
            end
            if (rsp_distance !== exp_res.distance_val) begin
               $display("%0t: distance expected %0d actual %0d", $time,
                        exp_res.distance_val, rsp_distance);
               failures++;
            end
            if (rsp_degenerate !== exp_res.degen) begin
               $display("%0t: degenerate expected %0b actual %0b", $time,
                        exp_res.degen, rsp_degenerate);
               failures++;
            end
         end
      end
   end

   // receiver stall, long hold counted here
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // called at a falling edge, returns at a falling edge with valid still driven
   task automatic send_query(coord_type qx, coord_type qy, logic seg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_query_x <= qx;
      req_query_y <= qy;
      req_segment_mode <= seg;
      do
         @(posedge clock);
      while (req_stall);
      expected_points.push_back(project_point(qx, qy, seg));
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (expected_points.size() != 0)
         @(posedge clock);
      repeat (70) @(negedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, coord_type val);
      @(negedge clock);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_START_X: line_regs.start_x = val;
         REG_START_Y: line_regs.start_y = val;
         REG_END_X:   line_regs.end_x = val;
         REG_END_Y:   line_regs.end_y = val;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 0;
   endtask

   task automatic set_line(coord_type sx, coord_type sy, coord_type ex, coord_type ey);
      drain();
      write_reg(REG_START_X, sx);
      write_reg(REG_START_Y, sy);
      write_reg(REG_END_X, ex);
      write_reg(REG_END_Y, ey);
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(3))
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom_range(4000)) - 2000);
         2: return coord_type'($signed($urandom_range(200000)) - 100000);
         default: return $urandom_range(1) ? coord_type'(24'sh7fffff - $urandom_range(3))
                                           : coord_type'(24'sh800000 + $urandom_range(3));
      endcase
   endfunction

   task automatic test_degenerate_line;
      send_query(24'sd0, 24'sd0, 1);
      send_query(24'sh7fffff, 24'sh7fffff, 0);
      send_query(24'sh800000, 24'sh800000, 1);
      send_query(24'sh800000, 24'sh7fffff, 0);
      set_line(24'sd1000, -24'sd500, 24'sd1000, -24'sd500);
      send_query(24'sd3, 24'sd4, 0);
   endtask

   task automatic test_extreme_line;
      set_line(24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff);
      send_query(24'sh800000, 24'sh7fffff, 1);
      send_query(24'sh7fffff, 24'sh800000, 0);
      send_query(24'sh7fffff, 24'sh7fffff, 1);
      send_query(24'sh800000, 24'sh800000, 0);
      send_query(24'sd0, 24'sd0, 1);
      set_line(24'sd0, 24'sd0, 24'sd1, 24'sd0);
      send_query(24'sh7fffff, 24'sh800000, 0);
      send_query(24'sh800000, 24'sh7fffff, 0);
      send_query(24'sh7fffff, 24'sd5, 1);
      send_query(-24'sd5, 24'sd5, 1);
      set_line(24'sh7fffff, 24'sh800000, 24'sh7ffffe, 24'sh800001);
      send_query(24'sh800000, 24'sh7fffff, 0);
      send_query(24'sh800000, 24'sh7fffff, 1);
      send_query(24'sh7fffff, 24'sh7fffff, 0);
      set_line(24'sd0, -24'sd256, 24'sd0, 24'sd256);
      send_query(24'sd100, 24'sd128, 1);
      send_query(24'sd100, 24'sd999, 1);
      send_query(24'sd100, 24'sd999, 0);
   endtask

   task automatic test_random_phase(int items);
      set_line(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      for (int i = 0; i < items; i++) begin
         if (i % 60 == 59)
            set_line(rand_coord(), rand_coord(), rand_coord(), rand_coord());
         send_query(rand_coord(), rand_coord(), 1'($urandom_range(1)));
      end
   endtask

   task automatic test_backpressure;
      set_line(-24'sd5000, 24'sd700, 24'sd9000, -24'sd3000);
      hold_cycles = 300;
      for (int i = 0; i < 100; i++)
         send_query(rand_coord(), rand_coord(), 1'($urandom_range(1)));
      drain();
      for (int i = 0; i < 20; i++)
         send_query(rand_coord(), rand_coord(), 1'($urandom_range(1)));
   endtask

   initial begin
      line_regs = '0;
      repeat (3) @(negedge clock);
      reset <= 0;
      test_degenerate_line();
      test_extreme_line();
      send_idle_pct = 31;
      recv_stall_pct = 67;
      test_random_phase(400);
      send_idle_pct = 67;
      recv_stall_pct = 31;
      test_random_phase(400);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_phase(400);
      test_backpressure();
      drain();
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire
